### src/spxd_pkg.sv
// Package for the sync pair XOR deframer: phase codes, register indexes,
// configuration struct and reset values. No dependencies.
package spxd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Largest payload length honored; longer settings are clamped
  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_BYTES = 8'd255;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN = 2'd2;

  // Reset values of the registers
  localparam logic [BYTE_W-1:0] RST_FIRST_SYNC  = 8'd170;
  localparam logic [BYTE_W-1:0] RST_SECOND_SYNC = 8'd85;
  localparam logic [BYTE_W-1:0] RST_PAYLOAD_LEN = 8'd32;

  // Frame phase
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SYNC2   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } phase_t;

  // Register contents handed to the frame logic
  typedef struct packed {
    logic [BYTE_W-1:0] first_sync;
    logic [BYTE_W-1:0] second_sync;
    logic [BYTE_W-1:0] payload_len;
  } cfg_t;

endpackage

### src/spxd_cfg_regs.sv
// Configuration registers of the deframer: sync values and payload length.
// Depends on spxd_pkg.
module spxd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spxd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spxd_pkg::BYTE_W-1:0]      cfg_data,
  output spxd_pkg::cfg_t                   cfg
);
  import spxd_pkg::*;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_sync  <= RST_FIRST_SYNC;
      cfg.second_sync <= RST_SECOND_SYNC;
      cfg.payload_len <= RST_PAYLOAD_LEN;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIRST_SYNC:  cfg.first_sync  <= cfg_data;
        REG_SECOND_SYNC: cfg.second_sync <= cfg_data;
        REG_PAYLOAD_LEN: cfg.payload_len <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### src/spxd_frame_core.sv
// Frame tracking datapath: input register, phase/count/XOR state and
// result register with stall handling. Depends on spxd_pkg.
module spxd_frame_core (
  input  logic                          clk,
  input  logic                          rst,
  input  spxd_pkg::cfg_t                cfg,
  input  logic                          rx_valid,
  output logic                          rx_stall,
  input  logic [spxd_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [spxd_pkg::BYTE_W-1:0]   out_byte,
  output logic                          frame_end,
  output logic                          checksum_ok
);
  import spxd_pkg::*;

  // Input stage
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_adv;
  logic              rx_take;

  // Frame state
  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] bytes_seen, bytes_seen_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;

  // Per-item results
  logic              emit;
  logic              emit_end;
  logic              emit_ok;
  logic [BYTE_W-1:0] eff_len;
  logic [BYTE_W:0]   cnt_inc;
  logic [BYTE_W-1:0] cnt_sat;
  logic              out_free;

  // Flow control: stage 1 moves when the result register is free
  assign out_free = !res_valid || !res_stall;
  assign s1_adv   = s1_valid && out_free;
  assign rx_stall = s1_valid && !out_free;
  assign rx_take  = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      s1_byte <= rx_byte;
    end
  end

  // Length clamp and saturating payload count
  assign eff_len = (cfg.payload_len > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES
                                                          : cfg.payload_len;
  assign cnt_inc = {1'b0, bytes_seen} + {{BYTE_W{1'b0}}, 1'b1};
  assign cnt_sat = cnt_inc[BYTE_W] ? {BYTE_W{1'b1}} : cnt_inc[BYTE_W-1:0];

  // Next state and result for the byte in stage 1
  always_comb begin
    phase_next       = phase;
    bytes_seen_next  = bytes_seen;
    running_xor_next = running_xor;
    emit             = 1'b0;
    emit_end         = 1'b0;
    emit_ok          = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (s1_byte == cfg.first_sync) phase_next = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (s1_byte == cfg.second_sync) begin
          bytes_seen_next  = '0;
          running_xor_next = '0;
          phase_next       = (eff_len == '0) ? PH_CHECK : PH_PAYLOAD;
        end else if (s1_byte != cfg.first_sync) begin
          phase_next = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        running_xor_next = running_xor ^ s1_byte;
        bytes_seen_next  = cnt_sat;
        if (cnt_sat >= eff_len) phase_next = PH_CHECK;
        emit = 1'b1;
      end
      PH_CHECK: begin
        emit             = 1'b1;
        emit_end         = 1'b1;
        emit_ok          = (s1_byte == running_xor);
        phase_next       = PH_HUNT;
        bytes_seen_next  = '0;
        running_xor_next = '0;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      bytes_seen  <= '0;
      running_xor <= '0;
    end else if (s1_adv) begin
      phase       <= phase_next;
      bytes_seen  <= bytes_seen_next;
      running_xor <= running_xor_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_adv && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_byte    <= s1_byte;
      frame_end   <= emit_end;
      checksum_ok <= emit_ok;
    end
  end

endmodule

### src/sync_pair_xor_deframer_unit.sv
// Top level of the sync pair XOR deframer.
// Depends on spxd_pkg, spxd_cfg_regs and spxd_frame_core.
//
// Use:
//   rx channel (rx_valid, rx_stall, rx_byte) carries received bytes; an item
//   is taken at a clock edge with rx_valid high and rx_stall low.
//   res channel (res_valid, res_stall, out_byte, frame_end, checksum_ok)
//   carries payload bytes (frame_end 0) and the checksum item that closes a
//   frame (frame_end 1, checksum_ok set when it matches the payload XOR).
//   Sync bytes and bytes outside a frame produce no item.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the first
//   sync value (0), second sync value (1) and payload length (2); ready is
//   always high. Write only while the block is idle.
// Timing: one byte per cycle sustained while res_stall does not hold the result
//   register. res_valid rises once its byte has passed the input register: the
//   frame state, the XOR and the result register then update in one pass.
// Reset (rst, synchronous): registers return to 170/85/32, the block hunts
//   for the first sync byte, both stages empty.
// Stall: a held result register holds the input register, and rx_stall
//   rises once that register is also full; nothing is dropped.
module sync_pair_xor_deframer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spxd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spxd_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                             rx_valid,
  output logic                             rx_stall,
  input  logic [spxd_pkg::BYTE_W-1:0]      rx_byte,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [spxd_pkg::BYTE_W-1:0]      out_byte,
  output logic                             frame_end,
  output logic                             checksum_ok
);
  import spxd_pkg::*;

  cfg_t cfg;

  // Configuration registers
  spxd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Frame datapath
  spxd_frame_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .out_byte    (out_byte),
    .frame_end   (frame_end),
    .checksum_ok (checksum_ok)
  );

endmodule
